FILE: design/llp_pkg.sv
// llp_pkg: shared types, site and weight codes, and pattern helpers for the
// loop link pattern R-matrix block. No dependencies.
`timescale 1ns / 1ps

package llp_pkg;

  localparam int MAX_SITES_DEF = 21;
  localparam int SITE_BITS     = 3;
  localparam int PAT_W         = 63;
  localparam int IDX_W         = 5;
  localparam int PAT_SITES     = PAT_W / SITE_BITS;

  typedef logic [SITE_BITS-1:0] site_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PAT_W-1:0]     pat_t;

  localparam site_t S_EMPTY = 3'd0;
  localparam site_t S_OPEN  = 3'd1;
  localparam site_t S_CLOSE = 3'd2;
  localparam site_t S_REF   = 3'd3;
  localparam site_t S_BOT   = 3'd4;
  localparam site_t S_MID   = 3'd5;

  localparam logic [1:0] WK_EMPTY    = 2'd0;
  localparam logic [1:0] WK_TURN     = 2'd1;
  localparam logic [1:0] WK_STRAIGHT = 2'd2;
  localparam logic [1:0] WK_FULL     = 2'd3;

  localparam logic [1:0] LF_NONE    = 2'd0;
  localparam logic [1:0] LF_CONTR   = 2'd1;
  localparam logic [1:0] LF_NONCONT = 2'd2;

  localparam logic REG_SITE_COUNT = 1'b0;
  localparam logic REG_MIN_DEFECT = 1'b1;

  // control word from the sequencer to the cell row
  typedef struct packed {
    logic load;
    logic rot_l;
    logic rot_r;
  } ring_ctl_t;

  function automatic logic defect_site(input site_t v);
    defect_site = (v == S_REF) || (v == S_BOT) || (v == S_MID);
  endfunction

  function automatic pat_t put_site(input pat_t p, input idx_t k, input site_t v);
    pat_t r;
    r = p;
    for (int i = 0; i < PAT_SITES; i++) begin
      if (k == IDX_W'(i)) r[SITE_BITS*i +: SITE_BITS] = v;
    end
    put_site = r;
  endfunction

endpackage

FILE: design/llp_cell.sv
// llp_cell: one ring site holding a 3-bit site code, loaded in parallel and
// shifted left or right to its neighbors. Depends on llp_pkg.
`timescale 1ns / 1ps

module llp_cell (
  input  logic              clk,
  input  llp_pkg::ring_ctl_t ctl,
  input  logic              active,
  input  llp_pkg::site_t    load_code,
  input  llp_pkg::site_t    from_right,
  input  llp_pkg::site_t    from_left,
  output llp_pkg::site_t    code
);

  llp_pkg::site_t code_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      code_r <= load_code;
    end else if (active && ctl.rot_l) begin
      code_r <= from_right;
    end else if (active && ctl.rot_r) begin
      code_r <= from_left;
    end
  end

  assign code = code_r;

endmodule

FILE: design/llp_ring.sv
// llp_ring: row of llp_cell sites closed into a ring of the active size;
// cell 0 is the head seen by the sequencer. Depends on llp_pkg, llp_cell.
`timescale 1ns / 1ps

module llp_ring #(
  parameter int MAX_SITES = llp_pkg::MAX_SITES_DEF
) (
  input  logic               clk,
  input  llp_pkg::ring_ctl_t ctl,
  input  llp_pkg::idx_t      ring,
  input  llp_pkg::pat_t      load_pattern,
  output llp_pkg::site_t     head,
  output llp_pkg::site_t     next_l,
  output llp_pkg::site_t     next_r
);

  llp_pkg::site_t codes [MAX_SITES];
  llp_pkg::site_t from_r [MAX_SITES];
  llp_pkg::site_t from_l [MAX_SITES];
  llp_pkg::site_t last_code;

  // site at ring-1 closes the ring on the left of the head
  always_comb begin
    last_code = llp_pkg::S_EMPTY;
    for (int i = 0; i < MAX_SITES; i++) begin
      if (ring == llp_pkg::IDX_W'(i + 1)) last_code = codes[i];
    end
  end

  for (genvar i = 0; i < MAX_SITES; i++) begin : g_cell
    if (i == MAX_SITES - 1) begin : g_end
      assign from_r[i] = codes[0];
    end else begin : g_mid
      assign from_r[i] = (ring == llp_pkg::IDX_W'(i + 1)) ? codes[0] : codes[i+1];
    end
    if (i == 0) begin : g_first
      assign from_l[i] = last_code;
    end else begin : g_rest
      assign from_l[i] = codes[i-1];
    end

    llp_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .active     (llp_pkg::IDX_W'(i) < ring),
      .load_code  (load_pattern[llp_pkg::SITE_BITS*i +: llp_pkg::SITE_BITS]),
      .from_right (from_r[i]),
      .from_left  (from_l[i]),
      .code       (codes[i])
    );
  end

  assign head   = codes[0];
  assign next_l = codes[1];
  assign next_r = last_code;

endmodule

FILE: design/loop_link_pattern_r_matrix.sv
// Loop link pattern R-matrix: takes a packed pattern and a position, emits two
// or three successor words tagged with weight kind and loop factor, or one
// plain word when both sites hold defects that do not fuse, or one word
// flagged bad when an arch end cannot be found. Items are handled one at a
// time; the sites sit in a row of cells that rotates one site per cycle
// inside the active ring. An item first reduces the position modulo the ring
// size and brings site a to the head, then runs up to two arch walks (with a
// re-seek to site b between them) or one defect count around the ring, then
// sends its words out one at a time, held while the receiver stalls. The
// next item is taken as soon as the last word of the current one sits in the
// output register. Depends on llp_pkg, llp_ring, llp_cell.
`timescale 1ns / 1ps

module loop_link_pattern_r_matrix #(
  parameter int MAX_SITES = llp_pkg::MAX_SITES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [62:0] link_pattern, [67:63] site_pos, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [62:0] new_pattern, [63] zero
  output logic [4:0]  out_tuser,  // [1:0] weight_kind, [3:2] loop_factor, [4] bad_pattern
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_SEEK, ST_DECIDE, ST_WALK, ST_COUNT, ST_BUILD, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {PC_EMPTY2, PC_ONE, PC_FULL, PC_BAD} pcase_t;

  logic [4:0] site_count_r, min_defect_r;

  state_t         state_r;
  pcase_t         case_r;
  llp_pkg::pat_t  p_r, base_r;
  llp_pkg::idx_t  ring_r, a_r, b_r, hidx_r, tgt_r, end_a_r, end_b_r, steps_r, dcnt_r;
  llp_pkg::site_t sa_r, sb_r, wcode_r;
  logic [4:0]     depth_r;
  logic [1:0]     n_r, idx_r, lf_r;
  logic           need_b_r, seek_b_r, dir_r, which_b_r, bad_r;

  logic                out_valid_r, out_last_r;
  logic [62:0]         out_pat_r;
  logic [4:0]          out_user_r;

  llp_pkg::ring_ctl_t ctl;
  llp_pkg::site_t     head, next_l, next_r;
  llp_pkg::idx_t      ring_clamp, hnext_l, hnext, b_calc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_count_r <= 5'd4;
      min_defect_r <= 5'd0;
    end else if (cfg_we) begin
      if (cfg_addr == llp_pkg::REG_SITE_COUNT) site_count_r <= cfg_wdata;
      if (cfg_addr == llp_pkg::REG_MIN_DEFECT) min_defect_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (site_count_r < 5'd2)                     ring_clamp = 5'd2;
    else if (site_count_r > 5'(MAX_SITES))       ring_clamp = 5'(MAX_SITES);
    else                                          ring_clamp = site_count_r;
  end

  assign in_tready = (state_r == ST_IDLE);
  wire accept = in_tvalid && in_tready;

  assign ctl.load  = accept;
  assign ctl.rot_l = ((state_r == ST_SEEK) && (hidx_r != tgt_r)) ||
                     ((state_r == ST_WALK) && dir_r) || (state_r == ST_COUNT);
  assign ctl.rot_r = (state_r == ST_WALK) && !dir_r;

  llp_ring #(.MAX_SITES(MAX_SITES)) u_ring (
    .clk          (clk),
    .ctl          (ctl),
    .ring         (ring_r),
    .load_pattern (in_tdata[62:0]),
    .head         (head),
    .next_l       (next_l),
    .next_r       (next_r)
  );

  assign hnext_l = (hidx_r + 5'd1 == ring_r) ? 5'd0 : hidx_r + 5'd1;
  assign hnext   = dir_r ? hnext_l : ((hidx_r == 5'd0) ? ring_r - 5'd1 : hidx_r - 5'd1);
  assign b_calc  = (a_r + 5'd1 == ring_r) ? 5'd0 : a_r + 5'd1;

  // one arch walk step: the site entering the head
  llp_pkg::site_t wc;
  logic [4:0]     depth_nxt;
  logic           w_found, w_fail;
  always_comb begin
    wc = dir_r ? next_l : next_r;
    depth_nxt = depth_r;
    if (wc == wcode_r) begin
      depth_nxt = depth_r + 5'd1;
    end else if ((dir_r && ({1'b0, wc} == {1'b0, wcode_r} + 4'd1)) ||
                 (!dir_r && ({1'b0, wc} + 4'd1 == {1'b0, wcode_r}))) begin
      depth_nxt = depth_r - 5'd1;
    end
    w_found = (depth_nxt == 5'd0);
    w_fail  = !w_found && (steps_r + 5'd1 == ring_r);
  end

  // decide on the pair at the head
  logic da_h, db_h, nd12_h, pair_h, need_a_h, need_b_h;
  always_comb begin
    da_h   = llp_pkg::defect_site(head);
    db_h   = llp_pkg::defect_site(next_l);
    nd12_h = ((head == llp_pkg::S_OPEN) || (head == llp_pkg::S_CLOSE)) &&
             ((next_l == llp_pkg::S_OPEN) || (next_l == llp_pkg::S_CLOSE));
    pair_h = ((head == llp_pkg::S_BOT) && (next_l == llp_pkg::S_MID)) ||
             ((head == llp_pkg::S_MID) && (next_l == llp_pkg::S_BOT));
    need_a_h = ((head == llp_pkg::S_CLOSE) && (next_l == llp_pkg::S_OPEN)) ||
               (db_h && !da_h) || nd12_h;
    need_b_h = (da_h && !db_h) || nd12_h;
  end

  // contracted pattern for the full case
  logic          da_s, db_s;
  llp_pkg::pat_t q_build;
  logic [1:0]    lf_build;
  always_comb begin
    da_s = llp_pkg::defect_site(sa_r);
    db_s = llp_pkg::defect_site(sb_r);
    q_build = p_r;
    if (da_s != db_s) begin
      q_build = llp_pkg::put_site(p_r, da_s ? end_b_r : end_a_r, da_s ? sa_r : sb_r);
    end else if (!da_s && (sa_r == llp_pkg::S_OPEN) && (sb_r == llp_pkg::S_OPEN)) begin
      q_build = llp_pkg::put_site(p_r, end_b_r, llp_pkg::S_OPEN);
    end else if (!da_s && (sa_r == llp_pkg::S_CLOSE) && (sb_r == llp_pkg::S_CLOSE)) begin
      q_build = llp_pkg::put_site(p_r, end_a_r, llp_pkg::S_CLOSE);
    end
    if ((sa_r == llp_pkg::S_OPEN) && (sb_r == llp_pkg::S_CLOSE))
      lf_build = llp_pkg::LF_CONTR;
    else if ((sa_r == llp_pkg::S_CLOSE) && (sb_r == llp_pkg::S_OPEN) && (end_a_r == b_r))
      lf_build = llp_pkg::LF_NONCONT;
    else
      lf_build = llp_pkg::LF_NONE;
  end

  // word selected for the output register
  llp_pkg::site_t ca, cb;
  logic [1:0]     wk_e, lf_e;
  logic [62:0]    pat_e;
  always_comb begin
    ca = llp_pkg::S_OPEN;
    cb = llp_pkg::S_CLOSE;
    lf_e = llp_pkg::LF_NONE;
    case (case_r)
      PC_EMPTY2: wk_e = (idx_r == 2'd0) ? llp_pkg::WK_EMPTY : llp_pkg::WK_TURN;
      PC_ONE: begin
        wk_e = (idx_r == 2'd0) ? llp_pkg::WK_TURN : llp_pkg::WK_STRAIGHT;
        ca = sb_r;
        cb = sa_r;
      end
      PC_FULL: begin
        wk_e = (idx_r == 2'd1) ? llp_pkg::WK_TURN : llp_pkg::WK_FULL;
        if (idx_r != 2'd0) lf_e = lf_r;
        if (idx_r == 2'd1) begin
          ca = llp_pkg::S_EMPTY;
          cb = llp_pkg::S_EMPTY;
        end
      end
      default: wk_e = llp_pkg::WK_EMPTY;
    endcase
    pat_e = (idx_r == 2'd0) ? p_r :
            llp_pkg::put_site(llp_pkg::put_site(base_r, a_r, ca), b_r, cb);
  end

  wire out_load = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            p_r      <= in_tdata[62:0];
            a_r      <= in_tdata[67:63];
            ring_r   <= ring_clamp;
            hidx_r   <= 5'd0;
            bad_r    <= 1'b0;
            seek_b_r <= 1'b0;
            state_r  <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (a_r >= ring_r) begin
            a_r <= a_r - ring_r;
          end else begin
            b_r     <= b_calc;
            tgt_r   <= a_r;
            state_r <= ST_SEEK;
          end
        end
        ST_SEEK: begin
          if (hidx_r != tgt_r) begin
            hidx_r <= hnext_l;
          end else if (seek_b_r) begin
            wcode_r   <= head;
            dir_r     <= (head == llp_pkg::S_OPEN);
            depth_r   <= 5'd1;
            steps_r   <= 5'd0;
            which_b_r <= 1'b1;
            state_r   <= ST_WALK;
          end else begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          sa_r     <= head;
          sb_r     <= next_l;
          need_b_r <= need_b_h;
          if ((head == llp_pkg::S_EMPTY) && (next_l == llp_pkg::S_EMPTY)) begin
            case_r  <= PC_EMPTY2;
            n_r     <= 2'd2;
            state_r <= ST_BUILD;
          end else if ((head == llp_pkg::S_EMPTY) || (next_l == llp_pkg::S_EMPTY)) begin
            case_r  <= PC_ONE;
            n_r     <= 2'd2;
            state_r <= ST_BUILD;
          end else begin
            case_r <= PC_FULL;
            n_r    <= 2'd3;
            if (da_h && db_h) begin
              if (pair_h) begin
                dcnt_r  <= 5'd0;
                steps_r <= 5'd0;
                state_r <= ST_COUNT;
              end else begin
                n_r     <= 2'd1;
                state_r <= ST_BUILD;
              end
            end else if (need_a_h) begin
              wcode_r   <= head;
              dir_r     <= (head == llp_pkg::S_OPEN);
              depth_r   <= 5'd1;
              steps_r   <= 5'd0;
              which_b_r <= 1'b0;
              state_r   <= ST_WALK;
            end else if (need_b_h) begin
              tgt_r    <= b_r;
              seek_b_r <= 1'b1;
              state_r  <= ST_SEEK;
            end else begin
              state_r <= ST_BUILD;
            end
          end
        end
        ST_WALK: begin
          hidx_r  <= hnext;
          depth_r <= depth_nxt;
          steps_r <= steps_r + 5'd1;
          if (w_found) begin
            if (which_b_r) begin
              end_b_r <= hnext;
              state_r <= ST_BUILD;
            end else begin
              end_a_r <= hnext;
              if (need_b_r) begin
                tgt_r    <= b_r;
                seek_b_r <= 1'b1;
                state_r  <= ST_SEEK;
              end else begin
                state_r <= ST_BUILD;
              end
            end
          end else if (w_fail) begin
            bad_r   <= 1'b1;
            state_r <= ST_BUILD;
          end
        end
        ST_COUNT: begin
          dcnt_r  <= dcnt_r + 5'(llp_pkg::defect_site(head));
          steps_r <= steps_r + 5'd1;
          if (steps_r + 5'd1 == ring_r) begin
            if ({1'b0, dcnt_r} + 6'(llp_pkg::defect_site(head)) >=
                {1'b0, min_defect_r} + 6'd2) begin
              n_r <= 2'd3;
            end else begin
              n_r <= 2'd1;
            end
            state_r <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          idx_r <= 2'd0;
          lf_r  <= lf_build;
          if (bad_r) begin
            case_r <= PC_BAD;
            n_r    <= 2'd1;
          end
          base_r  <= (case_r == PC_FULL) ? q_build : p_r;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            out_pat_r  <= pat_e;
            out_user_r <= {(case_r == PC_BAD), lf_e, wk_e};
            out_last_r <= (idx_r + 2'd1 == n_r);
            idx_r      <= idx_r + 2'd1;
            if (idx_r + 2'd1 == n_r) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pat_r};
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: design/llp_check.sv
// llp_check: port-level checks on the result stream of the R-matrix block,
// bound to loop_link_pattern_r_matrix. Depends on nothing else.
`timescale 1ns / 1ps

module llp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [4:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled word changed");

  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4] |-> out_tlast && (out_tuser[3:0] == 4'd0))
    else $error("bad word not single and plain");

  a_lf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[3:2] != 2'd3))
    else $error("loop factor out of range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("word valid after reset");

endmodule

bind loop_link_pattern_r_matrix llp_check u_llp_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: sim/loop_link_pattern_r_matrix_tb.sv
// Testbench for loop_link_pattern_r_matrix: random and directed patterns are
// streamed in, each result word is checked against an in-bench prediction.
// Depends on llp_pkg and the block's RTL.
`timescale 1ns / 1ps

module loop_link_pattern_r_matrix_tb;

  typedef struct packed {
    llp_pkg::pat_t pat;
    logic [1:0]    wk;
    logic [1:0]    lf;
    logic          bad;
    logic          last;
  } succ_t;

  typedef struct packed {
    llp_pkg::pat_t pat;
    llp_pkg::idx_t pos;
  } item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // [62:0] link_pattern, [67:63] site_pos, rest zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;  // [62:0] new_pattern, [63] zero
  logic [4:0]  out_tuser;  // [1:0] weight_kind, [3:2] loop_factor, [4] bad_pattern
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_addr;
  logic [4:0]  cfg_wdata;

  loop_link_pattern_r_matrix DUT (.*);

  item_t  pending_words[$];
  succ_t  expected_succ[$];
  int     mismatches = 0;
  int     cycle = 0;
  int     idle_pct = 17;
  bit     rx_hold = 0;
  bit     hold_go = 0;
  bit     hold_done = 0;
  bit     tx_pause = 0;
  int     ring_size = 4;
  int     min_defect_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic llp_pkg::site_t site_at(llp_pkg::pat_t p, int k);
    return p[llp_pkg::SITE_BITS*k +: llp_pkg::SITE_BITS];
  endfunction

  function automatic llp_pkg::pat_t put_code(llp_pkg::pat_t p, int k, llp_pkg::site_t v);
    p[llp_pkg::SITE_BITS*k +: llp_pkg::SITE_BITS] = v;
    return p;
  endfunction

  function automatic bit defect_code(llp_pkg::site_t v);
    return v == llp_pkg::S_REF || v == llp_pkg::S_BOT || v == llp_pkg::S_MID;
  endfunction

  // follow an arch from site k to its partner; failed set if it never closes
  function automatic int arch_partner(llp_pkg::pat_t p, int k, int n, inout bit failed);
    llp_pkg::site_t s, c;
    int j, depth;
    bit fwd;
    s = site_at(p, k);
    j = k;
    depth = 1;
    if (s == llp_pkg::S_EMPTY || defect_code(s)) return k;
    fwd = (s == llp_pkg::S_OPEN);
    for (int st = 0; st < n; st++) begin
      j = fwd ? (j + 1) % n : (j + n - 1) % n;
      c = site_at(p, j);
      if (c == s) depth++;
      else if ((fwd && {1'b0, c} == {1'b0, s} + 4'd1) ||
               (!fwd && {1'b0, c} + 4'd1 == {1'b0, s})) depth--;
      if (depth == 0) return j;
    end
    failed = 1;
    return k;
  endfunction

  task automatic predict_successors(item_t it);
    succ_t r[3];
    int n, a, b, cnt, e, d, arc, def, endp, e1, e2;
    llp_pkg::site_t sa, sb;
    bit failed, da, db, dc;
    llp_pkg::pat_t p, q;
    logic [1:0] lf;
    failed = 0;
    p = it.pat;
    a = it.pos % ring_size;
    b = (a + 1) % ring_size;
    sa = site_at(p, a);
    sb = site_at(p, b);
    for (int i = 0; i < 3; i++) r[i] = '0;
    if (sa == llp_pkg::S_EMPTY && sb == llp_pkg::S_EMPTY) begin
      r[0] = '{p, llp_pkg::WK_EMPTY, llp_pkg::LF_NONE, 0, 0};
      r[1] = '{put_code(put_code(p, a, llp_pkg::S_OPEN), b, llp_pkg::S_CLOSE),
               llp_pkg::WK_TURN, llp_pkg::LF_NONE, 0, 0};
      n = 2;
    end else if (sa == llp_pkg::S_EMPTY || sb == llp_pkg::S_EMPTY) begin
      e = (sa == llp_pkg::S_EMPTY) ? a : b;
      d = (sa == llp_pkg::S_EMPTY) ? b : a;
      q = put_code(put_code(p, e, site_at(p, d)), d, llp_pkg::S_EMPTY);
      r[0] = '{p, llp_pkg::WK_TURN, llp_pkg::LF_NONE, 0, 0};
      r[1] = '{q, llp_pkg::WK_STRAIGHT, llp_pkg::LF_NONE, 0, 0};
      n = 2;
    end else begin
      da = defect_code(sa);
      db = defect_code(sb);
      dc = 0;
      if (sa != llp_pkg::S_REF && sb != llp_pkg::S_REF &&
          ((sa == llp_pkg::S_BOT && sb == llp_pkg::S_MID) ||
           (sa == llp_pkg::S_MID && sb == llp_pkg::S_BOT))) begin
        cnt = 0;
        for (int k = 0; k < ring_size; k++) if (defect_code(site_at(p, k))) cnt++;
        dc = cnt >= min_defect_cnt + 2;
      end
      r[0] = '{p, llp_pkg::WK_FULL, llp_pkg::LF_NONE, 0, 0};
      n = 1;
      if (dc || !da || !db) begin
        q = p;
        lf = llp_pkg::LF_NONE;
        if (sa == llp_pkg::S_OPEN && sb == llp_pkg::S_CLOSE) lf = llp_pkg::LF_CONTR;
        else if (sa == llp_pkg::S_CLOSE && sb == llp_pkg::S_OPEN &&
                 arch_partner(p, a, ring_size, failed) == b)
          lf = llp_pkg::LF_NONCONT;
        if (da != db) begin
          arc = da ? b : a;
          def = da ? a : b;
          endp = arch_partner(p, arc, ring_size, failed);
          q = put_code(q, endp, site_at(p, def));
        end else if (!dc) begin
          if ((sa == llp_pkg::S_OPEN || sa == llp_pkg::S_CLOSE) &&
              (sb == llp_pkg::S_OPEN || sb == llp_pkg::S_CLOSE)) begin
            e1 = arch_partner(p, a, ring_size, failed);
            e2 = arch_partner(p, b, ring_size, failed);
            if (sa == llp_pkg::S_OPEN && sb == llp_pkg::S_OPEN)
              q = put_code(q, e2, llp_pkg::S_OPEN);
            else if (sa == llp_pkg::S_CLOSE && sb == llp_pkg::S_CLOSE)
              q = put_code(q, e1, llp_pkg::S_CLOSE);
          end
        end
        r[1] = '{put_code(put_code(q, a, llp_pkg::S_EMPTY), b, llp_pkg::S_EMPTY),
                 llp_pkg::WK_TURN, lf, 0, 0};
        r[2] = '{put_code(put_code(q, a, llp_pkg::S_OPEN), b, llp_pkg::S_CLOSE),
                 llp_pkg::WK_FULL, lf, 0, 0};
        n = 3;
      end
    end
    if (failed) begin
      r[0] = '{p, llp_pkg::WK_EMPTY, llp_pkg::LF_NONE, 1, 1};
      n = 1;
    end
    r[n-1].last = 1;
    for (int i = 0; i < n; i++) expected_succ.push_back(r[i]);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle, what);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_successors(pending_words.pop_front());
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() > 0 && !tx_pause &&
            $urandom_range(99) >= idle_pct) begin
          in_tvalid <= 1;
          in_tdata <= {4'b0, pending_words[0].pos, pending_words[0].pat};
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    succ_t w;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_succ.size() == 0) begin
          report_mismatch("unexpected word");
        end else begin
          w = expected_succ.pop_front();
          if (out_tdata[62:0] !== w.pat)
            report_mismatch($sformatf("pattern %h expected %h", out_tdata[62:0], w.pat));
          if (out_tdata[63] !== 1'b0) report_mismatch("pad bit set");
          if (out_tuser[1:0] !== w.wk)
            report_mismatch($sformatf("weight kind %0d expected %0d", out_tuser[1:0], w.wk));
          if (out_tuser[3:2] !== w.lf)
            report_mismatch($sformatf("loop factor %0d expected %0d", out_tuser[3:2], w.lf));
          if (out_tuser[4] !== w.bad)
            report_mismatch($sformatf("bad flag %0d expected %0d", out_tuser[4], w.bad));
          if (out_tlast !== w.last)
            report_mismatch($sformatf("last %0d expected %0d", out_tlast, w.last));
        end
      end
      out_tready <= !rx_hold && $urandom_range(99) >= idle_pct;
    end
  end

  // receiver hold-off, counted in clock cycles
  initial begin
    wait (hold_go);
    rx_hold = 1;
    repeat (300) @(posedge clk);
    rx_hold = 0;
    hold_done = 1;
  end

  initial begin
    wait (cycle >= 400000);
    $display("FAILURE");
    $finish;
  end

  function automatic llp_pkg::pat_t rand_pat();
    return llp_pkg::PAT_W'({$urandom(), $urandom()});
  endfunction

  // patterns built from well-formed arches with scattered defects
  function automatic llp_pkg::pat_t wellformed_pat(int n);
    llp_pkg::pat_t p;
    int stack[$];
    int k, d;
    p = rand_pat();
    for (k = 0; k < n; k++) p = put_code(p, k, llp_pkg::S_EMPTY);
    for (k = 0; k < n; k++) begin
      d = $urandom_range(9);
      if (d < 3) begin
        p = put_code(p, k, llp_pkg::S_OPEN);
        stack.push_back(k);
      end else if (d < 6 && stack.size() > 0) begin
        p = put_code(p, k, llp_pkg::S_CLOSE);
        void'(stack.pop_back());
      end else if (d == 6) begin
        p = put_code(p, k, llp_pkg::site_t'($urandom_range(5, 3)));
      end
    end
    // clear leftover unmatched opens to empty sites
    while (stack.size() > 0) begin
      k = stack.pop_back();
      p = put_code(p, k, llp_pkg::S_EMPTY);
    end
    return p;
  endfunction

  task automatic push_item(llp_pkg::pat_t p, int pos);
    item_t it;
    it.pat = p;
    it.pos = llp_pkg::idx_t'(pos);
    pending_words.push_back(it);
  endtask

  task automatic wait_drained();
    wait (pending_words.size() == 0 && !in_tvalid);
    wait (expected_succ.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, int val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_wdata <= 5'(val);
    @(posedge clk);
    cfg_we <= 0;
    if (addr == llp_pkg::REG_SITE_COUNT) ring_size = val < 2 ? 2 : (val > 21 ? 21 : val);
    else min_defect_cnt = val;
  endtask

  task automatic random_phase(int count, int n);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) != 0) push_item(wellformed_pat(n), $urandom_range(31));
      else push_item(rand_pat(), $urandom_range(31));
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_addr = llp_pkg::REG_SITE_COUNT;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed, default ring of four
    push_item('0, 0);
    push_item({63{1'b1}}, 31);
    push_item(put_code('0, 1, llp_pkg::S_OPEN), 0);
    push_item(put_code('0, 0, llp_pkg::S_BOT), 0);
    push_item(put_code(put_code('0, 0, llp_pkg::S_OPEN), 1, llp_pkg::S_CLOSE), 0);
    push_item(put_code(put_code('0, 0, llp_pkg::S_CLOSE), 1, llp_pkg::S_OPEN), 0);
    push_item(put_code(put_code(put_code(put_code('0, 0, llp_pkg::S_CLOSE), 1,
                                                  llp_pkg::S_OPEN), 2, llp_pkg::S_CLOSE),
                       3, llp_pkg::S_OPEN), 0);
    push_item(put_code(put_code('0, 0, llp_pkg::S_OPEN), 1, llp_pkg::S_OPEN), 0);
    push_item(put_code(put_code('0, 2, llp_pkg::S_BOT), 3, llp_pkg::S_MID), 2);
    push_item(put_code(put_code('0, 2, llp_pkg::S_REF), 3, llp_pkg::S_MID), 2);
    push_item(put_code(put_code('0, 3, llp_pkg::S_OPEN), 0, llp_pkg::S_BOT), 3);
    push_item(put_code(put_code('0, 0, 3'd6), 1, 3'd7), 0);
    push_item(put_code(put_code('0, 0, 3'd7), 1, 3'd6), 0);
    push_item(put_code(put_code('0, 0, llp_pkg::S_OPEN), 1, llp_pkg::S_MID), 0);
    wait_drained();

    write_reg(llp_pkg::REG_SITE_COUNT, 0);
    write_reg(llp_pkg::REG_MIN_DEFECT, 31);
    push_item(put_code(put_code('0, 0, llp_pkg::S_MID), 1, llp_pkg::S_BOT), 1);
    push_item(rand_pat(), 5);
    random_phase(15, 2);
    wait_drained();

    write_reg(llp_pkg::REG_SITE_COUNT, 31);
    write_reg(llp_pkg::REG_MIN_DEFECT, 0);
    idle_pct = 0;
    random_phase(40, 21);
    wait_drained();

    // long receiver hold so the block backs up
    idle_pct = 17;
    hold_go = 1;
    random_phase(10, 21);
    wait (hold_done);
    wait_drained();

    write_reg(llp_pkg::REG_SITE_COUNT, 8);
    write_reg(llp_pkg::REG_MIN_DEFECT, 2);
    random_phase(40, 8);
    repeat (60) @(posedge clk);
    tx_pause = 1;
    wait (expected_succ.size() == 0 && !in_tvalid);
    wait (expected_succ.size() == 0);
    tx_pause = 0;
    wait_drained();

    write_reg(llp_pkg::REG_SITE_COUNT, 21);
    write_reg(llp_pkg::REG_MIN_DEFECT, 21);
    random_phase(30, 21);
    wait_drained();

    write_reg(llp_pkg::REG_SITE_COUNT, 13);
    write_reg(llp_pkg::REG_MIN_DEFECT, 1);
    random_phase(30, 13);
    wait_drained();

    if (mismatches == 0 && expected_succ.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
